FILE: sv/rotate_xor_password_hash_defines.svh
// assertion macros shared by the hash block
`ifndef ROTATE_XOR_PASSWORD_HASH_DEFINES_SVH
`define ROTATE_XOR_PASSWORD_HASH_DEFINES_SVH

// antecedent holds now, consequent holds in the same cycle
`define RXPH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds now, consequent holds in the next cycle
`define RXPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rxph_pkg.sv
package rxph_pkg;

  localparam logic [31:0] SEED_VALUE = 32'hDEADBEEF;
  localparam logic [31:0] SALT_VALUE = 32'hA5A5A5A5;
  localparam logic [31:0] SHORT_OR   = 32'h55555555;
  localparam logic [31:0] SHORT_XOR  = 32'hAAAAAAAA;

  localparam int unsigned POS_W = 3;

  typedef logic [31:0]      hash_t;
  typedef logic [7:0]       char_t;
  typedef logic [POS_W-1:0] pos_t;

  // request kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // one byte folded into the hash, byte placed in lane pos[1:0]
  function automatic hash_t absorb_mix(hash_t h_in, char_t b, pos_t pos);
    hash_t lane;
    hash_t h;
    begin
      lane = {24'd0, b} << {pos[1:0], 3'b000};
      h = h_in ^ lane;
      h = {h[18:0], h[31:19]} ^ SALT_VALUE;
      h = h ^ (h >> 11);
      h = {h[24:0], h[31:25]} ^ (h >> 16);
      return h;
    end
  endfunction

  // extra round for passwords shorter than eight bytes
  function automatic hash_t short_mix(hash_t h_in);
    hash_t h;
    begin
      h = h_in ^ ((h_in << 17) | SHORT_OR);
      h = {h[28:0], h[31:29]} ^ SHORT_XOR;
      return h;
    end
  endfunction

endpackage

FILE: sv/rxph_ifs.sv
interface rxph_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  rxph_pkg::char_t     char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface rxph_out_if;
  logic                valid;
  logic                ready;
  rxph_pkg::hash_t     digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

FILE: sv/rotate_xor_password_hash.sv
// a finish request passes the input stage and then the result stage, which holds its
//   digest until it is taken; bytes produce no result
// throughput: one request per cycle while no finish waits on an untaken digest; the hash
//   update loop closes through the mixing logic in front of the running hash register
// only a finish waits on an untaken digest, and requests behind it wait with it
// reset (rst, synchronous, active high): seed, count and flag cleared, both stages empty
`include "rotate_xor_password_hash_defines.svh"

module rotate_xor_password_hash (
  input  logic       clk,
  input  logic       rst,
  rxph_in_if.sink    pw_in,
  rxph_out_if.source digest_out
);
  import rxph_pkg::*;

  // input stage: one request held ahead of the mixing logic
  logic  in_valid;
  logic  in_kind;
  char_t in_byte;

  // hash state
  hash_t running_hash;
  pos_t  byte_position;
  logic  reached_eight;

  // result stage
  logic  out_valid;
  hash_t digest;

  logic  stage_go;       // input stage request consumed this cycle
  logic  byte_go;
  logic  finish_go;
  hash_t running_hash_next;
  hash_t digest_next;

  // a byte never needs the result stage; a finish needs it empty or draining
  assign stage_go  = in_valid &&
                     ((in_kind == KIND_BYTE) || !out_valid || digest_out.ready);
  assign byte_go   = stage_go && (in_kind == KIND_BYTE);
  assign finish_go = stage_go && (in_kind == KIND_FINISH);

  // the input stage takes a new request whenever it is empty or moving on
  assign pw_in.ready = !in_valid || stage_go;

  assign running_hash_next = absorb_mix(running_hash, in_byte, byte_position);

  // short passwords get the extra round before the digest leaves
  always_comb begin
    if (reached_eight) begin
      digest_next = running_hash;
    end else begin
      digest_next = short_mix(running_hash);
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pw_in.ready) begin
      in_valid <= pw_in.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (pw_in.ready && pw_in.valid) begin
      in_kind <= pw_in.kind;
      in_byte <= pw_in.char_byte;
    end
  end

  // hash state: bytes fold in, a finish returns to the seed
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= SEED_VALUE;
      byte_position <= '0;
      reached_eight <= 1'b0;
    end else if (finish_go) begin
      running_hash  <= SEED_VALUE;
      byte_position <= '0;
      reached_eight <= 1'b0;
    end else if (byte_go) begin
      running_hash  <= running_hash_next;
      byte_position <= byte_position + pos_t'(1);
      if (byte_position == pos_t'((1 << POS_W) - 1)) begin
        reached_eight <= 1'b1;
      end
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (digest_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (finish_go) begin
      digest <= digest_next;
    end
  end

  assign digest_out.valid  = out_valid;
  assign digest_out.digest = digest;

  // a finish leaves the state at the seed with the count cleared
  `RXPH_ASSERT_NEXT(a_finish_reseeds, clk, rst, finish_go,
    (running_hash == SEED_VALUE) && (byte_position == '0) && !reached_eight,
    "state not back at seed after finish")
  // the eighth byte sets the long-password flag
  `RXPH_ASSERT_NEXT(a_eighth_byte_flags, clk, rst,
    byte_go && (byte_position == pos_t'((1 << POS_W) - 1)), reached_eight,
    "eight-byte flag not set")
  // a finish always lands in the result stage
  `RXPH_ASSERT_NEXT(a_finish_lands, clk, rst, finish_go, out_valid,
    "digest not presented after finish")
  // a finish never overwrites an untaken digest
  `RXPH_ASSERT_SAME(a_no_overwrite, clk, rst, finish_go,
    !out_valid || digest_out.ready, "digest overwritten while stalled")

endmodule
